// ===== sv/strd_pkg.sv =====
// Shared types and constants of the signed-token run-length decoder.
package strd_pkg;

   localparam int unsigned TOTAL_WIDTH = 27;
   localparam int unsigned COUNT_WIDTH = 16;

   localparam logic [TOTAL_WIDTH-1:0] TOTAL_MASK  = {TOTAL_WIDTH{1'b1}};
   localparam logic [TOTAL_WIDTH-1:0] LIMIT_RESET = 27'd67108864;
   localparam logic [32:0] MAX_OUTPUT_BYTES_DEFAULT = 33'd67108864;

   // Depth of the queue between the parser and the run unit; a power of two.
   localparam int unsigned FIFO_DEPTH = 2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_OVER  = 2'd2;

   typedef enum logic [2:0] {
      PH_TOKEN_LOW,
      PH_TOKEN_HIGH,
      PH_REPEAT_BYTE,
      PH_LITERAL,
      PH_DISCARD
   } phase_type;

   // Work handed from the parser to the run unit.
   typedef enum logic [1:0] {
      OP_RUN,
      OP_LIT,
      OP_END,
      OP_CLEAR
   } op_kind_type;

   typedef struct packed {
      op_kind_type            kind;
      logic [7:0]             data_byte;
      logic [COUNT_WIDTH-1:0] count;
      logic                   last;
   } op_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic                   run_valid;
      logic [7:0]             out_value;
      logic [COUNT_WIDTH-1:0] repeat_count;
      logic                   end_of_image;
      logic [1:0]             end_status;
      logic [TOTAL_WIDTH-1:0] total_length;
   } rsp_payload_type;

endpackage

// ===== sv/strd_if.sv =====
// Valid/ready channel interfaces for packed input bytes and decoded results.
interface strd_req_if;
   logic                      valid;
   logic                      ready;
   strd_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface strd_rsp_if;
   logic                      valid;
   logic                      ready;
   strd_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/signed_token_rle_decoder.sv =====
// Top level of the signed-token run-length decoder.
//
// The block takes one packed byte per transaction on req_chan (data_byte plus
// a last_byte mark) and returns decoded runs on rsp_chan. Tokens are
// little-endian signed 16-bit values: negative repeats the next byte, positive
// copies that many literal bytes, zero ends the image. Each result carries a
// value with its repeat count, an end flag with status, and the running total.
// The user writes the limit on the decoded total through csr_write_enable
// and csr_write_data only while the block is idle; the block does not check.
//
// A byte that causes a result is classified by the parser in the accepting
// cycle and written into the queue, and the run unit then loads its result
// register from the queue. One byte is accepted every cycle while the queue
// has room. When the receiver stalls, the result register holds its
// transaction and the two-entry queue absorbs the bytes in flight;
// req_chan.ready drops only when the queue is full. Reset clears the parser,
// the queue, the total and the result register, and restores the limit to
// its power-on value.
module signed_token_rle_decoder #(
   parameter logic [32:0] MAX_OUTPUT_BYTES = strd_pkg::MAX_OUTPUT_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   strd_req_if.sink                          req_chan,
   strd_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [strd_pkg::TOTAL_WIDTH-1:0]  csr_write_data
);
   // Output limit register; the run unit caps it by the build-time maximum.
   logic [strd_pkg::TOTAL_WIDTH-1:0] output_limit_ff, output_limit_in;

   // Parser to queue.
   logic             push_valid;
   logic             push_ready;
   strd_pkg::op_type push_op;

   // Queue to run unit.
   logic             pop_valid;
   logic             pop_ready;
   strd_pkg::op_type pop_op;

   always_comb begin
      output_limit_in = csr_write_enable ? csr_write_data : output_limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         output_limit_ff <= strd_pkg::LIMIT_RESET;
      end else begin
         output_limit_ff <= output_limit_in;
      end
   end

   // The parser follows token structure only; limit decisions are left to
   // the run unit, which skips the rest of an image that ran over.
   strd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_ready (push_ready)
   );

   strd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_op     (pop_op),
      .pop_ready  (pop_ready)
   );

   strd_back #(
      .MAX_OUTPUT_BYTES (MAX_OUTPUT_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .limit     (output_limit_ff),
      .pop_valid (pop_valid),
      .pop_op    (pop_op),
      .pop_ready (pop_ready),
      .rsp       (rsp_chan)
   );

   // A result without decoded bytes is always the end of an image.
   a_empty_result_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.payload.run_valid
      |-> rsp_chan.payload.end_of_image)
      else $error("result without a run that does not end the image");

   // Every reported run covers at least one byte.
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.run_valid
      |-> rsp_chan.payload.repeat_count != '0)
      else $error("reported run has a zero repeat count");

   // Status is only meaningful on an end.
   a_status_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.payload.end_of_image
      |-> rsp_chan.payload.end_status == strd_pkg::ST_OK)
      else $error("end status set on a result that does not end the image");

endmodule

// ===== sv/strd_fifo.sv =====
// Short queue of parsed operations between the token parser and the run unit.
module strd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  strd_pkg::op_type push_op,
   output logic             push_ready,
   output logic             pop_valid,
   output strd_pkg::op_type pop_op,
   input  logic             pop_ready
);
   localparam int unsigned PTR_WIDTH = (strd_pkg::FIFO_DEPTH > 1) ?
                                       $clog2(strd_pkg::FIFO_DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(strd_pkg::FIFO_DEPTH + 1);
   localparam logic [CNT_WIDTH-1:0] DEPTH_CNT = CNT_WIDTH'(strd_pkg::FIFO_DEPTH);

   strd_pkg::op_type     entries_ff [strd_pkg::FIFO_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 push, pop;

   assign push_ready = (count_ff != DEPTH_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue fill count exceeds its depth");

   a_pop_moves_read_side: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue fill count did not follow a lone read");

endmodule

// ===== sv/strd_front.sv =====
// Token parser: tracks the token structure of the packed stream and queues operations.
module strd_front (
   input  logic             clock,
   input  logic             reset,
   strd_req_if.sink         req,
   output logic             push_valid,
   output strd_pkg::op_type push_op,
   input  logic             push_ready
);
   strd_pkg::phase_type    phase_ff, phase_in;
   logic [7:0]             token_low_ff, token_low_in;
   logic [15:0]            pending_ff, pending_in;
   logic                   accept;
   logic [15:0]            raw;
   logic                   last;

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;
   assign last      = req.payload.last_byte;
   assign raw       = {req.payload.data_byte, token_low_ff};

   always_comb begin
      phase_in          = phase_ff;
      token_low_in      = token_low_ff;
      pending_in        = pending_ff;
      push_valid        = 1'b0;
      push_op.kind      = strd_pkg::OP_END;
      push_op.data_byte = req.payload.data_byte;
      push_op.count     = pending_ff;
      push_op.last      = last;
      if (accept) begin
         case (phase_ff)
            strd_pkg::PH_TOKEN_LOW: begin
               token_low_in = req.payload.data_byte;
               if (last) begin
                  push_valid = 1'b1;
               end else begin
                  phase_in = strd_pkg::PH_TOKEN_HIGH;
               end
            end
            strd_pkg::PH_TOKEN_HIGH: begin
               if (raw == '0) begin
                  push_valid = 1'b1;
                  phase_in   = last ? strd_pkg::PH_TOKEN_LOW : strd_pkg::PH_DISCARD;
               end else if (last) begin
                  // The stream stopped before the token's body arrived.
                  push_valid = 1'b1;
                  phase_in   = strd_pkg::PH_TOKEN_LOW;
               end else if (raw[15]) begin
                  pending_in = 16'd0 - raw;
                  phase_in   = strd_pkg::PH_REPEAT_BYTE;
               end else begin
                  pending_in = raw;
                  phase_in   = strd_pkg::PH_LITERAL;
               end
            end
            strd_pkg::PH_REPEAT_BYTE: begin
               push_valid   = 1'b1;
               push_op.kind = strd_pkg::OP_RUN;
               phase_in     = strd_pkg::PH_TOKEN_LOW;
            end
            strd_pkg::PH_LITERAL: begin
               push_valid   = 1'b1;
               push_op.kind = strd_pkg::OP_LIT;
               pending_in   = pending_ff - 16'd1;
               if (last || pending_ff == 16'd1) begin
                  phase_in = strd_pkg::PH_TOKEN_LOW;
               end
            end
            strd_pkg::PH_DISCARD: begin
               if (last) begin
                  push_valid   = 1'b1;
                  push_op.kind = strd_pkg::OP_CLEAR;
                  phase_in     = strd_pkg::PH_TOKEN_LOW;
               end
            end
            default: begin
               phase_in = strd_pkg::PH_TOKEN_LOW;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= strd_pkg::PH_TOKEN_LOW;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      token_low_ff <= token_low_in;
      pending_ff   <= pending_in;
   end

endmodule

// ===== sv/strd_back.sv =====
// Run unit: applies the output limit, keeps the decoded total and registers results.
module strd_back #(
   parameter logic [32:0] MAX_OUTPUT_BYTES = strd_pkg::MAX_OUTPUT_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [strd_pkg::TOTAL_WIDTH-1:0]  limit,
   input  logic                              pop_valid,
   input  strd_pkg::op_type                  pop_op,
   output logic                              pop_ready,
   strd_rsp_if.source                        rsp
);
   localparam logic [strd_pkg::TOTAL_WIDTH-1:0] LIMIT_CAP =
      (MAX_OUTPUT_BYTES > {6'd0, strd_pkg::TOTAL_MASK}) ?
      strd_pkg::TOTAL_MASK : MAX_OUTPUT_BYTES[strd_pkg::TOTAL_WIDTH-1:0];

   logic                              discard_ff, discard_in;
   logic [strd_pkg::TOTAL_WIDTH-1:0]  total_ff, total_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   strd_pkg::rsp_payload_type         rsp_payload_ff, rsp_payload_in;
   logic                              load, take, emit;
   logic [strd_pkg::TOTAL_WIDTH-1:0]  lim;
   logic [strd_pkg::TOTAL_WIDTH:0]    run_sum;
   logic [1:0]                        quiet_status;

   assign load      = !rsp_valid_ff || rsp.ready;
   assign pop_ready = load;
   assign take      = pop_valid && load;
   assign lim       = (limit < LIMIT_CAP) ? limit : LIMIT_CAP;
   assign run_sum   = {1'b0, total_ff} + {{(strd_pkg::TOTAL_WIDTH + 1 -
                        strd_pkg::COUNT_WIDTH){1'b0}}, pop_op.count};
   assign quiet_status = (total_ff != '0) ? strd_pkg::ST_OK : strd_pkg::ST_EMPTY;

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_payload_ff;

   always_comb begin
      discard_in                  = discard_ff;
      total_in                    = total_ff;
      emit                        = 1'b0;
      rsp_payload_in.run_valid    = 1'b0;
      rsp_payload_in.out_value    = '0;
      rsp_payload_in.repeat_count = '0;
      rsp_payload_in.end_of_image = 1'b1;
      rsp_payload_in.end_status   = strd_pkg::ST_OK;
      rsp_payload_in.total_length = total_ff;
      if (take && !discard_ff) begin
         case (pop_op.kind)
            strd_pkg::OP_END: begin
               emit                      = 1'b1;
               rsp_payload_in.end_status = quiet_status;
            end
            strd_pkg::OP_RUN: begin
               emit = 1'b1;
               if (run_sum > {1'b0, lim}) begin
                  rsp_payload_in.end_status = strd_pkg::ST_OVER;
               end else begin
                  total_in                    = run_sum[strd_pkg::TOTAL_WIDTH-1:0];
                  rsp_payload_in.run_valid    = 1'b1;
                  rsp_payload_in.out_value    = pop_op.data_byte;
                  rsp_payload_in.repeat_count = pop_op.count;
                  rsp_payload_in.end_of_image = pop_op.last;
                  rsp_payload_in.total_length = total_in;
               end
            end
            strd_pkg::OP_LIT: begin
               emit = 1'b1;
               if (total_ff >= lim) begin
                  rsp_payload_in.end_status = strd_pkg::ST_OVER;
               end else begin
                  total_in                    = total_ff + 1'b1;
                  rsp_payload_in.run_valid    = 1'b1;
                  rsp_payload_in.out_value    = pop_op.data_byte;
                  rsp_payload_in.repeat_count = strd_pkg::COUNT_WIDTH'(1);
                  rsp_payload_in.end_of_image = pop_op.last;
                  rsp_payload_in.total_length = total_in;
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
         // An end that is not on the last byte skips the rest of the image.
         if (emit && rsp_payload_in.end_of_image && !pop_op.last) begin
            discard_in = 1'b1;
         end
      end
      if (take && pop_op.last) begin
         discard_in = 1'b0;
         total_in   = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = take && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         discard_ff   <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         discard_ff   <= discard_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   a_over_has_no_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.end_status == strd_pkg::ST_OVER
      |-> !rsp_payload_ff.run_valid && rsp_payload_ff.end_of_image)
      else $error("over-limit result carries a run");

   a_last_clears_total: assert property (@(posedge clock) disable iff (reset)
      take && pop_op.last |=> total_ff == '0 && !discard_ff)
      else $error("last byte did not rearm the run unit");

endmodule

// ===== tb/sv/signed_token_rle_decoder_tb.sv =====
// Self-checking testbench for the signed-token run-length decoder.
module signed_token_rle_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Bytes sent per random phase, counting the bytes the block discards.
   localparam int PHASE_ITEMS    = 210;
   // Cycles the receiver holds off during the back-pressure phase.
   localparam int LONG_HOLD      = 400;
   // Cycles allowed after the last expected run before the block is called idle.
   // A byte that causes no run passes only the parser and queue, so it is gone by then.
   localparam int SETTLE_CYCLES  = 8;
   // Cycles without any transaction after which the run is declared hung.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   // The scoreboard tracks the decoder state. It turns every accepted byte into
   // the runs that byte should produce and checks each result against the oldest one.
   class run_scoreboard;
      logic [strd_pkg::TOTAL_WIDTH-1:0] limit_reg     = strd_pkg::LIMIT_RESET;
      strd_pkg::phase_type              phase         = strd_pkg::PH_TOKEN_LOW;
      logic [7:0]                       token_low     = 8'd0;
      logic [strd_pkg::COUNT_WIDTH-1:0] pending_count = '0;
      logic [strd_pkg::TOTAL_WIDTH-1:0] decoded_total = '0;
      strd_pkg::rsp_payload_type        expected_runs[$];
      int                               mismatch_count = 0;
      int                               accepted_bytes = 0;

      function void clear_image();
         phase         = strd_pkg::PH_TOKEN_LOW;
         token_low     = 8'd0;
         pending_count = '0;
         decoded_total = '0;
      endfunction

      function logic [1:0] quiet_status();
         return (decoded_total != 0) ? strd_pkg::ST_OK : strd_pkg::ST_EMPTY;
      endfunction

      function void push_run(bit valid, logic [7:0] value,
                             logic [strd_pkg::COUNT_WIDTH-1:0] count,
                             bit image_end, logic [1:0] status);
         strd_pkg::rsp_payload_type run;
         run.run_valid    = valid;
         run.out_value    = value;
         run.repeat_count = count;
         run.end_of_image = image_end;
         run.end_status   = status;
         run.total_length = decoded_total;
         expected_runs.push_back(run);
      endfunction

      // Reports the end of the image, then either rearms or skips to the last byte.
      function void end_image(bit last, bit valid, logic [7:0] value,
                              logic [strd_pkg::COUNT_WIDTH-1:0] count,
                              logic [1:0] status);
         push_run(valid, value, count, 1'b1, status);
         if (last) clear_image();
         else phase = strd_pkg::PH_DISCARD;
      endfunction

      function void decode_byte(strd_pkg::req_payload_type item);
         logic [15:0]                      raw;
         logic [strd_pkg::COUNT_WIDTH-1:0] run_len;
         longint unsigned                  lim;
         longint unsigned                  room;
         bit                               last;
         last = item.last_byte;
         lim  = limit_reg;
         if (lim > strd_pkg::MAX_OUTPUT_BYTES_DEFAULT)
            lim = strd_pkg::MAX_OUTPUT_BYTES_DEFAULT;
         accepted_bytes++;
         case (phase)
            strd_pkg::PH_TOKEN_LOW: begin
               token_low = item.data_byte;
               if (last) end_image(1'b1, 1'b0, 8'd0, '0, quiet_status());
               else phase = strd_pkg::PH_TOKEN_HIGH;
            end
            strd_pkg::PH_TOKEN_HIGH: begin
               raw = {item.data_byte, token_low};
               if (raw == 16'd0) begin
                  end_image(last, 1'b0, 8'd0, '0, quiet_status());
               end else begin
                  if (raw[15]) begin
                     pending_count = 16'd0 - raw;
                     phase = strd_pkg::PH_REPEAT_BYTE;
                  end else begin
                     pending_count = raw;
                     phase = strd_pkg::PH_LITERAL;
                  end
                  if (last) end_image(1'b1, 1'b0, 8'd0, '0, quiet_status());
               end
            end
            strd_pkg::PH_REPEAT_BYTE: begin
               run_len = pending_count;
               room = (decoded_total <= lim) ? lim - decoded_total : 0;
               pending_count = '0;
               if (run_len > room) begin
                  end_image(last, 1'b0, 8'd0, '0, strd_pkg::ST_OVER);
               end else begin
                  decoded_total = decoded_total + run_len;
                  if (last) begin
                     end_image(1'b1, 1'b1, item.data_byte, run_len, strd_pkg::ST_OK);
                  end else begin
                     phase = strd_pkg::PH_TOKEN_LOW;
                     push_run(1'b1, item.data_byte, run_len, 1'b0, strd_pkg::ST_OK);
                  end
               end
            end
            strd_pkg::PH_LITERAL: begin
               // Literal bytes are checked against the limit one at a time.
               if (decoded_total >= lim) begin
                  pending_count = '0;
                  end_image(last, 1'b0, 8'd0, '0, strd_pkg::ST_OVER);
               end else begin
                  decoded_total = decoded_total + 1'b1;
                  pending_count = pending_count - 1'b1;
                  if (last) begin
                     end_image(1'b1, 1'b1, item.data_byte, 16'd1, strd_pkg::ST_OK);
                  end else begin
                     if (pending_count == 0) phase = strd_pkg::PH_TOKEN_LOW;
                     push_run(1'b1, item.data_byte, 16'd1, 1'b0, strd_pkg::ST_OK);
                  end
               end
            end
            default: begin
               if (last) clear_image();
               else phase = strd_pkg::PH_DISCARD;
            end
         endcase
      endfunction

      function void check_run(strd_pkg::rsp_payload_type got);
         strd_pkg::rsp_payload_type want;
         if (expected_runs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display({"Unexpected run: valid=%0d value=%02h count=%0d end=%0d",
                         " status=%0d total=%0d"},
                        got.run_valid, got.out_value, got.repeat_count, got.end_of_image,
                        got.end_status, got.total_length);
            return;
         end
         want = expected_runs.pop_front();
         if (got.run_valid !== want.run_valid || got.out_value !== want.out_value ||
             got.repeat_count !== want.repeat_count ||
             got.end_of_image !== want.end_of_image ||
             got.end_status !== want.end_status ||
             got.total_length !== want.total_length) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display({"Run mismatch, expected: valid=%0d value=%02h count=%0d",
                         " end=%0d status=%0d total=%0d"},
                        want.run_valid, want.out_value, want.repeat_count,
                        want.end_of_image, want.end_status, want.total_length);
               $display({"             actual:   valid=%0d value=%02h count=%0d",
                         " end=%0d status=%0d total=%0d"},
                        got.run_valid, got.out_value, got.repeat_count,
                        got.end_of_image, got.end_status, got.total_length);
            end
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             csr_write_enable;
   logic [strd_pkg::TOTAL_WIDTH-1:0] csr_write_data;

   strd_req_if req_chan ();
   strd_rsp_if rsp_chan ();

   run_scoreboard             sb;
   strd_pkg::req_payload_type image_bytes[$];

   // Idling odds in percent, set per phase by the stimulus process.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   // Each increment asks the receiver for one long hold-off.
   int hold_requests  = 0;

   signed_token_rle_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Both channels are observed at the rising edge. A transaction on the input
   // channel feeds the predictor, and a transaction on the result channel is checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) sb.decode_byte(req_chan.payload);
         if (rsp_chan.valid && rsp_chan.ready) sb.check_run(rsp_chan.payload);
      end
   end

   // The receiver stalls at random. When a long hold-off is requested, it keeps
   // ready low until the hold-off runs out, so that the block fills up.
   initial begin : receiver
      int served;
      int remaining;
      served = 0;
      remaining = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (served != hold_requests) begin
            served++;
            remaining = LONG_HOLD;
         end
         if (remaining > 0) begin
            remaining--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // The watchdog ends a hung run. Any transaction restarts its count.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [7:0] random_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void put_byte(logic [7:0] value);
      image_bytes.push_back({value, 1'b0});
   endfunction

   // Tokens are little-endian: the low byte goes first.
   function automatic void put_token(logic [15:0] raw);
      put_byte(raw[7:0]);
      put_byte(raw[15:8]);
   endfunction

   function automatic void mark_last();
      image_bytes[image_bytes.size() - 1].last_byte = 1'b1;
   endfunction

   // Mostly short runs, some that strain small limits, and now and then the extremes.
   function automatic int pick_run_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 16);
      if (roll < 92) return $urandom_range(17, 400);
      if (roll < 97) return $urandom_range(401, 32768);
      return (roll == 97) ? 32768 : 1;
   endfunction

   // Builds one packed image. Most images are well formed, with random tokens and
   // one of the ways an image can end. The rest are plain random bytes.
   function automatic void build_image();
      int ending;
      int ntok;
      int span;
      image_bytes.delete();
      ending = $urandom_range(0, 9);
      if (ending == 9) begin
         repeat ($urandom_range(1, 8)) put_byte(random_byte());
      end else begin
         ntok = $urandom_range(0, 5);
         if ((ending == 4 || ending == 5) && ntok == 0) ntok = 1;
         repeat (ntok) begin
            if ($urandom_range(0, 1) == 0) begin
               put_token(16'(0 - pick_run_length()));
               put_byte(random_byte());
            end else begin
               span = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 6) :
                                                    $urandom_range(7, 40);
               put_token(16'(span));
               repeat (span) put_byte(random_byte());
            end
         end
         case (ending)
            0, 1, 2, 3: begin
               // Zero token, then a few bytes that the block must throw away.
               put_token(16'd0);
               repeat ($urandom_range(0, 3)) put_byte(random_byte());
            end
            6: put_byte(random_byte());
            7: put_token(16'(0 - pick_run_length()));
            8: begin
               span = $urandom_range(2, 40);
               put_token(16'(span));
               repeat ($urandom_range(0, span - 1)) put_byte(random_byte());
            end
            default: ;
         endcase
      end
      mark_last();
   endfunction

   // Offers one byte, with a random gap first, and returns at the edge where the
   // transaction completes. Valid stays high so back-to-back bytes need no bubble.
   task automatic send_byte(input strd_pkg::req_payload_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_image();
      foreach (image_bytes[i]) send_byte(image_bytes[i]);
   endtask

   // Stops offering bytes and waits until every expected run has arrived and
   // any byte that produces no run has left the pipeline.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_runs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One phase: the block is drained, the limit is written, and random images
   // are sent under the given idling odds, with an optional long hold-off and a drain halfway.
   task automatic run_phase(input logic [strd_pkg::TOTAL_WIDTH-1:0] limit_value,
                            input int send_pct, input int recv_pct,
                            input bit long_hold, input bit mid_pause);
      int  start_count;
      bit  paused;
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= limit_value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.limit_reg   = limit_value;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      // The sender keeps offering bytes while the receiver holds off.
      if (long_hold) hold_requests++;
      start_count = sb.accepted_bytes;
      paused = 1'b0;
      while (sb.accepted_bytes - start_count < PHASE_ITEMS) begin
         if (mid_pause && !paused &&
             sb.accepted_bytes - start_count >= PHASE_ITEMS / 2) begin
            drain();
            paused = 1'b1;
         end
         build_image();
         send_image();
      end
   endtask

   initial begin : stimulus
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      sb = new;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed images under the power-on limit. The first holds the shortest
      // and longest runs and a single literal, ends on a zero token, and is
      // followed by a byte that is discarded up to the last-byte mark.
      image_bytes.delete();
      put_token(16'hFFFF);
      put_byte(8'h00);
      put_token(16'h8000);
      put_byte(8'hFF);
      put_token(16'h0001);
      put_byte(8'hA5);
      put_token(16'h0000);
      put_byte(8'h5A);
      mark_last();
      // A zero token carrying the last mark is an empty image.
      put_token(16'h0000);
      mark_last();
      // A lone token byte at the end of the stream.
      put_byte(8'h7F);
      mark_last();
      // A repeat token with no byte to repeat.
      put_token(16'hFFFE);
      mark_last();
      // The longest literal token, cut short after two bytes.
      put_token(16'h7FFF);
      put_byte(8'h80);
      put_byte(8'h01);
      mark_last();
      // A run completed by the last byte reports the run and the end together.
      put_token(16'hFFFC);
      put_byte(8'h42);
      mark_last();
      send_image();

      // Random phases: every idling pattern, limits from zero to the top of the range.
      run_phase(27'd0, 0, 0, 1'b0, 1'b0);
      run_phase(strd_pkg::LIMIT_RESET, 68, 0, 1'b0, 1'b0);
      run_phase(27'd300, 0, 68, 1'b1, 1'b0);
      run_phase(27'd37, 36, 36, 1'b0, 1'b0);
      run_phase(27'($urandom_range(0, 2000)), 0, 0, 1'b0, 1'b1);
      run_phase(27'd1, 68, 0, 1'b0, 1'b0);
      run_phase(27'd67108863, 0, 68, 1'b0, 1'b0);
      run_phase(27'($urandom_range(0, 67108864)), 36, 36, 1'b0, 1'b0);

      drain();
      if (sb.mismatch_count == 0 && sb.expected_runs.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== signed_token_rle_decoder.f =====
sv/strd_pkg.sv
sv/strd_if.sv
sv/strd_fifo.sv
sv/strd_front.sv
sv/strd_back.sv
sv/signed_token_rle_decoder.sv
tb/sv/signed_token_rle_decoder_tb.sv
